FILE: sv/bounded_message_queue_with_eviction_macros.svh
`ifndef BOUNDED_MESSAGE_QUEUE_WITH_EVICTION_MACROS_SVH
`define BOUNDED_MESSAGE_QUEUE_WITH_EVICTION_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BMQ_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bmq assertion failed");

// Next-cycle implication, checked outside reset.
`define BMQ_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bmq assertion failed");

`endif

FILE: sv/bmq_pkg.sv
`timescale 1ns / 1ps

package bmq_pkg;

  localparam int QUEUE_DEPTH_DEF = 128;

  localparam logic [1:0] CMD_ENQ = 2'd0;
  localparam logic [1:0] CMD_DEQ = 2'd1;
  localparam logic [1:0] CMD_CLR = 2'd2;

  localparam logic [1:0] REG_SESSION = 2'd0;
  localparam logic [1:0] REG_MASK    = 2'd1;
  localparam logic [1:0] REG_GEN     = 2'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic [5:0]  msg_type;
    logic [31:0] payload_handle;
    logic        must_deliver;
  } req_t;

  typedef struct packed {
    logic        accepted;
    logic        out_valid;
    logic [5:0]  out_type;
    logic [31:0] out_sequence;
    logic [31:0] out_generation;
    logic [31:0] out_payload;
    logic        evicted_one;
    logic        dropped_new;
    logic [7:0]  fill_level;
  } rsp_t;

  typedef struct packed {
    logic [5:0]  msg_type;
    logic [31:0] seq_no;
    logic [31:0] payload;
  } entry_t;

endpackage

FILE: sv/bmq_ram.sv
`timescale 1ns / 1ps

module bmq_ram #(
  parameter int DEPTH = 128,
  parameter int AW    = 7,
  parameter int WIDTH = 70
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/bounded_message_queue_with_eviction.sv
`timescale 1ns / 1ps

// Bounded outgoing message queue with a drop policy. Entries live in one ring
// memory (head pointer plus count) with a registered read port. An accepted
// request beat is decoded in the next cycle (state EXEC), and its response is
// then loaded into the output register in state OUT, which waits while the
// output register holds an untaken response. Enqueue into a non-full queue,
// refused enqueue, clear and an empty dequeue go from EXEC straight to OUT;
// a dequeue first passes through state DEQ because it waits for the memory
// read. Enqueue into a full queue of a non-must-deliver message scans the
// ring for the oldest non-critical entry (one read a cycle) and then closes
// the gap by copying each later entry one slot toward the head (one copy a
// cycle). The copy starts right behind the victim, so scan and copy together
// touch each entry once, and a drop of the new message follows a scan of the
// whole ring. The next request beat is taken as soon as the response is in
// the output register, even while it waits to be taken.
// Configuration registers may be written only while no request is in flight.
module bounded_message_queue_with_eviction #(
  parameter int QUEUE_DEPTH = bmq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_addr,
  input  logic [63:0]   cfg_wdata,
  input  logic          req_valid,
  output logic          req_ready,
  input  bmq_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output bmq_pkg::rsp_t rsp
);

  import bmq_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = CW + 1;
  localparam int EW = $bits(entry_t);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
  localparam logic [SW-1:0] DEPTH_S = SW'(QUEUE_DEPTH);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_EXEC  = 3'd1;
  localparam logic [2:0] ST_SRCH  = 3'd2;
  localparam logic [2:0] ST_SHIFT = 3'd3;
  localparam logic [2:0] ST_DEQ   = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  // configuration
  logic        session_open;
  logic [63:0] crit_mask;
  logic [31:0] gen_stamp;

  // control and state registers
  logic [2:0]    state, state_next;
  req_t          cur, cur_next;
  logic [31:0]   cur_seq, cur_seq_next;
  logic [CW-1:0] count, count_next;
  logic [AW-1:0] head, head_next;
  logic [31:0]   next_seq, next_seq_next;
  logic [CW-1:0] idx, idx_next;
  logic          chk_vld, chk_vld_next;
  logic [CW-1:0] chk_idx, chk_idx_next;
  rsp_t          rbuild, rbuild_next;
  rsp_t          rsp_q, rsp_q_next;
  logic          rsp_vld, rsp_vld_next;

  // memory port
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [EW-1:0] mem_rdata_raw;
  entry_t        mem_rdata;

  logic [CW+7:0] count_ext;

  // logical position k to ring address
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] hd, input logic [CW-1:0] k);
    logic [SW-1:0] sum;
    sum = {{(SW-AW){1'b0}}, hd} + {1'b0, k};
    if (sum >= DEPTH_S) begin
      sum = sum - DEPTH_S;
    end
    return sum[AW-1:0];
  endfunction

  bmq_ram #(
    .DEPTH(QUEUE_DEPTH),
    .AW   (AW),
    .WIDTH(EW)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata_raw)
  );

  assign mem_rdata = entry_t'(mem_rdata_raw);
  assign count_ext = {8'b0, count};

  always_comb begin
    state_next    = state;
    cur_next      = cur;
    cur_seq_next  = cur_seq;
    count_next    = count;
    head_next     = head;
    next_seq_next = next_seq;
    idx_next      = idx;
    chk_vld_next  = chk_vld;
    chk_idx_next  = chk_idx;
    rbuild_next   = rbuild;
    rsp_q_next    = rsp_q;
    rsp_vld_next  = rsp_vld;
    req_ready     = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = phys(head, count);
    mem_wdata     = '{msg_type: cur.msg_type, seq_no: cur_seq, payload: cur.payload_handle};
    mem_raddr     = head;

    if (rsp_vld && rsp_ready) begin
      rsp_vld_next = 1'b0;
    end

    case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cur_next   = req;
          state_next = ST_EXEC;
        end
      end

      ST_EXEC: begin
        rbuild_next = '0;
        state_next  = ST_OUT;
        case (cur.command)
          CMD_ENQ: begin
            if (!session_open) begin
              rbuild_next.accepted = ~cur.must_deliver;
            end else begin
              next_seq_next        = next_seq + 32'd1;
              cur_seq_next         = next_seq;
              rbuild_next.accepted = 1'b1;
              if (count < DEPTH_C) begin
                mem_we     = 1'b1;
                mem_waddr  = phys(head, count);
                mem_wdata  = '{msg_type: cur.msg_type, seq_no: next_seq,
                               payload: cur.payload_handle};
                count_next = count + CW'(1);
              end else if (cur.must_deliver) begin
                rbuild_next.accepted = 1'b0;
              end else begin
                idx_next     = '0;
                chk_vld_next = 1'b0;
                state_next   = ST_SRCH;
              end
            end
          end
          CMD_DEQ: begin
            if (count != '0) begin
              mem_raddr  = head;
              state_next = ST_DEQ;
            end
          end
          CMD_CLR: begin
            count_next = '0;
          end
          default: begin
          end
        endcase
      end

      // scan from the head for the oldest evictable entry
      ST_SRCH: begin
        mem_raddr = phys(head, idx);
        if (chk_vld && !crit_mask[mem_rdata.msg_type]) begin
          rbuild_next.evicted_one = 1'b1;
          idx_next     = chk_idx + CW'(1);
          chk_vld_next = 1'b0;
          state_next   = ST_SHIFT;
        end else if (chk_vld && chk_idx == count - CW'(1)) begin
          rbuild_next.dropped_new = 1'b1;
          chk_vld_next = 1'b0;
          state_next   = ST_OUT;
        end else if (idx < count) begin
          chk_vld_next = 1'b1;
          chk_idx_next = idx;
          idx_next     = idx + CW'(1);
        end else begin
          chk_vld_next = 1'b0;
        end
      end

      // copy each later entry one slot toward the head, then append
      ST_SHIFT: begin
        mem_raddr = phys(head, idx);
        if (chk_vld) begin
          mem_we    = 1'b1;
          mem_waddr = phys(head, chk_idx);
          mem_wdata = mem_rdata;
        end
        if (idx < count) begin
          chk_vld_next = 1'b1;
          chk_idx_next = idx - CW'(1);
          idx_next     = idx + CW'(1);
        end else begin
          chk_vld_next = 1'b0;
          if (!chk_vld) begin
            mem_we     = 1'b1;
            mem_waddr  = phys(head, count - CW'(1));
            state_next = ST_OUT;
          end
        end
      end

      ST_DEQ: begin
        rbuild_next.out_valid      = 1'b1;
        rbuild_next.out_type       = mem_rdata.msg_type;
        rbuild_next.out_sequence   = mem_rdata.seq_no;
        rbuild_next.out_generation = gen_stamp;
        rbuild_next.out_payload    = mem_rdata.payload;
        head_next  = phys(head, CW'(1));
        count_next = count - CW'(1);
        state_next = ST_OUT;
      end

      ST_OUT: begin
        if (!rsp_vld || rsp_ready) begin
          rsp_q_next            = rbuild;
          rsp_q_next.fill_level = count_ext[7:0];
          rsp_vld_next          = 1'b1;
          state_next            = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      count        <= '0;
      head         <= '0;
      next_seq     <= '0;
      chk_vld      <= 1'b0;
      rsp_vld      <= 1'b0;
      session_open <= 1'b0;
      crit_mask    <= '0;
      gen_stamp    <= '0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      head     <= head_next;
      next_seq <= next_seq_next;
      chk_vld  <= chk_vld_next;
      rsp_vld  <= rsp_vld_next;
      if (cfg_we) begin
        case (cfg_addr)
          REG_SESSION: session_open <= cfg_wdata[0];
          REG_MASK:    crit_mask    <= cfg_wdata;
          REG_GEN:     gen_stamp    <= cfg_wdata[31:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cur     <= cur_next;
    cur_seq <= cur_seq_next;
    idx     <= idx_next;
    chk_idx <= chk_idx_next;
    rbuild  <= rbuild_next;
    rsp_q   <= rsp_q_next;
  end

  assign rsp_valid = rsp_vld;
  assign rsp       = rsp_q;

endmodule

FILE: sv/bmq_checker.sv
`timescale 1ns / 1ps

`include "bounded_message_queue_with_eviction_macros.svh"

module bmq_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input bmq_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input bmq_pkg::rsp_t rsp
);

  import bmq_pkg::*;

  logic no_msg_zero;
  logic req_seen;

  assign no_msg_zero = rsp.out_type == 6'd0 && rsp.out_sequence == 32'd0 &&
                       rsp.out_generation == 32'd0 && rsp.out_payload == 32'd0;
  assign req_seen    = req_valid && req_ready && req.command == req.command;

  // message fields stay zero when no message was popped
  `BMQ_ASSERT_IMP(a_empty_fields, clk, rst, rsp_valid && !rsp.out_valid, no_msg_zero)
  // a dropped message is reported accepted and never together with an eviction
  `BMQ_ASSERT_IMP(a_drop_flags, clk, rst, rsp_valid && rsp.dropped_new,
                  rsp.accepted && !rsp.evicted_one)
  // one request in flight: no new beat right after an accepted one
  `BMQ_ASSERT_NXT(a_one_in_flight, clk, rst, req_seen, !req_ready)
  // hold a stalled response beat
  `BMQ_ASSERT_NXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready,
                  rsp_valid && $stable(rsp))

endmodule

bind bounded_message_queue_with_eviction bmq_checker u_bmq_checker (.*);
